>>> src/sadsc_pkg.sv
// ----------------------------------------------------------------------------
// sadsc_pkg
// Shared types and constants of the SAD stereo cost volume block.
// ----------------------------------------------------------------------------
package sadsc_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_ROWS = 2'd0;
  localparam logic [1:0] CFG_COLS = 2'd1;
  localparam logic [1:0] CFG_DISP = 2'd2;
  localparam logic [1:0] CFG_DIR  = 2'd3;

  localparam int CFG_AW = 2;
  localparam int CFG_DW = 11;

  // item counter width
  localparam int KW = 21;

  // counter widths sized for the largest window and disparity range
  localparam int WIN_IW = 3;
  localparam int DISP_W = 7;

  // register reset values
  localparam logic [10:0] ROWS_RST = 11'd480;
  localparam logic [10:0] COLS_RST = 11'd640;
  localparam logic [6:0]  DISP_RST = 7'd64;
  localparam logic [1:0]  DIR_RST  = 2'b11;

  // controller to datapath
  typedef struct packed {
    logic                accept;
    logic                acc_clr;
    logic                row_init;
    logic                row_next;
    logic                tap;
    logic                out_load;
    logic [WIN_IW-1:0]   col_tap;
    logic [DISP_W-1:0]   disp;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cfg_busy;
    logic emit;
    logic last_d;
    logic out_fire;
  } status_t;

endpackage

>>> src/sad_stereo_cost_volume.sv
// ----------------------------------------------------------------------------
// sad_stereo_cost_volume
// SAD block-matching stereo cost volume over a square window, streamed.
// ----------------------------------------------------------------------------
// Left/right pixel pairs enter in raster order (tuser 0), drain beats
// (tuser 1) follow the frame. Each beat that reaches a centre pixel emits
// one cost per configured disparity. A beat that emits nothing does not
// hold off the input; a beat that emits holds the input off until the last
// cost of its run is taken. Costs come from the single SAD datapath that
// reads one window tap per cycle from one read port on each pixel store.
// After reset and after every configuration write the input is held off
// while derived frame values settle.
module sad_stereo_cost_volume #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_DISP   = 64,
  parameter int WINDOW     = 5,
  parameter int STORE_ROWS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sadsc_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [sadsc_pkg::CFG_DW-1:0]  cfg_data,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [15:0]                   s_tdata,   // left_pixel, right_pixel
  input  logic                          s_tuser,   // func
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [39:0]                   m_tdata,   // cost, disparity, pixel_row, pixel_col
  output logic                          m_tlast    // last
);

  sadsc_pkg::cmd_t    cmd;
  sadsc_pkg::status_t stat;

  sadsc_ctrl #(
    .WINDOW (WINDOW)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  sadsc_dp #(
    .MAX_COLS   (MAX_COLS),
    .MAX_ROWS   (MAX_ROWS),
    .MAX_DISP   (MAX_DISP),
    .WINDOW     (WINDOW),
    .STORE_ROWS (STORE_ROWS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .cmd      (cmd),
    .stat     (stat)
  );

endmodule

>>> src/sadsc_dp.sv
// ----------------------------------------------------------------------------
// sadsc_dp
// Datapath: config registers, pixel stores, item counter, tap address and
// bounds logic, SAD accumulator and output register.
// ----------------------------------------------------------------------------
module sadsc_dp #(
  parameter int MAX_COLS   = 1024,
  parameter int MAX_ROWS   = 1024,
  parameter int MAX_DISP   = 64,
  parameter int WINDOW     = 5,
  parameter int STORE_ROWS = 8
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [sadsc_pkg::CFG_AW-1:0]  cfg_addr,
  input  logic [sadsc_pkg::CFG_DW-1:0]  cfg_data,
  input  logic [15:0]                   s_tdata,
  input  logic                          s_tuser,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic [39:0]                   m_tdata,
  output logic                          m_tlast,
  input  sadsc_pkg::cmd_t               cmd,
  output sadsc_pkg::status_t            stat
);

  localparam int H     = WINDOW / 2;
  localparam int RW1   = $clog2(MAX_ROWS + 1);
  localparam int CW1   = $clog2(MAX_COLS + 1);
  localparam int RW    = $clog2(MAX_ROWS);
  localparam int CW    = $clog2(MAX_COLS);
  localparam int AW    = $clog2(STORE_ROWS * MAX_COLS);
  localparam int DEPTH = 1 << AW;
  localparam int TW    = RW1 + CW1;
  localparam int CMPW  = ((sadsc_pkg::KW > TW) ? sadsc_pkg::KW : TW) + 2;
  localparam int XW    = CW1 + 8;
  localparam int YW    = RW1 + 2;
  localparam int SW    = $clog2(WINDOW * WINDOW * 255 + 1);
  localparam int DW    = sadsc_pkg::DISP_W;

  // raw config registers
  logic [10:0] rows_r;
  logic [10:0] cols_r;
  logic [6:0]  nd_r;
  logic [1:0]  dir_r;
  logic [1:0]  settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_r <= sadsc_pkg::ROWS_RST;
      cols_r <= sadsc_pkg::COLS_RST;
      nd_r   <= sadsc_pkg::DISP_RST;
      dir_r  <= sadsc_pkg::DIR_RST;
      settle <= 2'd3;
    end else if (cfg_we) begin
      settle <= 2'd3;
      case (cfg_addr)
        sadsc_pkg::CFG_ROWS: rows_r <= cfg_data;
        sadsc_pkg::CFG_COLS: cols_r <= cfg_data;
        sadsc_pkg::CFG_DISP: nd_r   <= cfg_data[6:0];
        sadsc_pkg::CFG_DIR:  dir_r  <= cfg_data[1:0];
        default: ;
      endcase
    end else if (settle != 2'd0) begin
      settle <= settle - 2'd1;
    end
  end

  // derived config, three register stages
  logic [RW1-1:0]   rows_c;
  logic [CW1-1:0]   cols_c;
  logic [DW-1:0]    nd_c;
  logic signed [1:0] dir_c;
  logic [TW-1:0]    total;
  logic [CW1+2:0]   hcols;
  logic [CMPW-1:0]  lag;
  logic [CMPW-1:0]  endk;
  logic [CMPW-1:0]  total_x;

  always_ff @(posedge clk) begin
    if (rows_r == 11'd0) rows_c <= RW1'(1);
    else if (CMPW'(rows_r) > CMPW'(MAX_ROWS)) rows_c <= RW1'(MAX_ROWS);
    else rows_c <= RW1'(rows_r);
    if (cols_r == 11'd0) cols_c <= CW1'(1);
    else if (CMPW'(cols_r) > CMPW'(MAX_COLS)) cols_c <= CW1'(MAX_COLS);
    else cols_c <= CW1'(cols_r);
    if (nd_r == 7'd0) nd_c <= DW'(1);
    else if (CMPW'(nd_r) > CMPW'(MAX_DISP)) nd_c <= DW'(MAX_DISP);
    else nd_c <= DW'(nd_r);
    if (dir_r == 2'd1) dir_c <= 2'sd1;
    else if (dir_r == 2'd0) dir_c <= 2'sd0;
    else dir_c <= -2'sd1;
    total <= TW'(rows_c) * TW'(cols_c);
    hcols <= (CW1 + 3)'(H * cols_c);
    lag   <= CMPW'(H * cols_c) + CMPW'(H) + CMPW'(nd_c) - CMPW'(1);
    endk  <= CMPW'(total) - CMPW'(1) + lag;
  end

  assign total_x = CMPW'(total);

  // item acceptance
  logic [sadsc_pkg::KW-1:0] k;
  logic [CMPW-1:0]          kx;
  logic [CMPW-1:0]          cdiff;
  logic                     idle_item;
  logic                     emit;
  logic                     wr_en;
  logic                     at_end;

  assign kx        = CMPW'(k);
  assign cdiff     = kx - lag;
  assign idle_item = s_tuser && (kx < total_x);
  assign emit      = !idle_item && (kx >= lag) && (cdiff < total_x);
  assign wr_en     = cmd.accept && !s_tuser && (kx < total_x);
  assign at_end    = kx >= endk;

  // item counter and centre position
  logic [RW-1:0] crow;
  logic [CW-1:0] ccol;
  logic [RW-1:0] cur_row;
  logic [CW-1:0] cur_col;
  logic [AW-1:0] cpos;

  always_ff @(posedge clk) begin
    if (rst) begin
      k    <= '0;
      crow <= '0;
      ccol <= '0;
    end else if (cmd.accept && !idle_item) begin
      if (at_end) begin
        k    <= '0;
        crow <= '0;
        ccol <= '0;
      end else begin
        k <= k + 1'b1;
        if (emit) begin
          if (CW1'(ccol) == cols_c - CW1'(1)) begin
            ccol <= '0;
            crow <= crow + 1'b1;
          end else begin
            ccol <= ccol + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && emit) begin
      cur_row <= crow;
      cur_col <= ccol;
      cpos    <= cdiff[AW-1:0];
    end
  end

  // window row tracking
  logic [AW-1:0]        row_base;
  logic signed [YW-1:0] ycur;

  always_ff @(posedge clk) begin
    if (cmd.row_init) begin
      row_base <= cpos - AW'(hcols);
      ycur     <= $signed(YW'(cur_row)) - $signed(YW'(H));
    end else if (cmd.row_next) begin
      row_base <= row_base + AW'(cols_c);
      ycur     <= ycur + $signed(YW'(1));
    end
  end

  // tap address and bounds
  logic signed [XW-1:0] xl;
  logic signed [XW-1:0] xr;
  logic signed [XW-1:0] dsh;
  logic                 tap_ok;
  logic [AW-1:0]        addr_l;
  logic [AW-1:0]        addr_r;

  always_comb begin
    if (dir_c == 2'sd1) dsh = $signed(XW'(cmd.disp));
    else if (dir_c == 2'sd0) dsh = '0;
    else dsh = -$signed(XW'(cmd.disp));
    xl = $signed(XW'(cur_col)) + $signed(XW'(cmd.col_tap)) - $signed(XW'(H));
    xr = xl + dsh;
    tap_ok = (ycur >= 0) && (ycur < $signed(YW'(rows_c)))
          && (xl >= 0) && (xl < $signed(XW'(cols_c)))
          && (xr >= 0) && (xr < $signed(XW'(cols_c)));
    addr_l = row_base + AW'(cmd.col_tap) - AW'(H);
    addr_r = addr_l + AW'(dsh);
  end

  // pixel stores
  logic [7:0] lmem [DEPTH];
  logic [7:0] rmem [DEPTH];
  logic [7:0] ldat;
  logic [7:0] rdat;

  always_ff @(posedge clk) begin
    if (wr_en) lmem[k[AW-1:0]] <= s_tdata[7:0];
    ldat <= lmem[addr_l];
  end

  always_ff @(posedge clk) begin
    if (wr_en) rmem[k[AW-1:0]] <= s_tdata[15:8];
    rdat <= rmem[addr_r];
  end

  // absolute difference and accumulate
  logic          tap_v;
  logic [SW-1:0] acc;
  logic [7:0]    absd;

  assign absd = (ldat > rdat) ? (ldat - rdat) : (rdat - ldat);

  always_ff @(posedge clk) begin
    if (rst) tap_v <= 1'b0;
    else tap_v <= cmd.tap && tap_ok;
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_clr) acc <= '0;
    else if (tap_v) acc <= acc + SW'(absd);
  end

  // output register
  logic [SW+12:0] acc_ext;
  logic [DW+5:0]  disp_ext;
  logic [RW+9:0]  row_ext;
  logic [CW+9:0]  col_ext;
  logic [12:0]    o_cost;
  logic [5:0]     o_disp;
  logic [9:0]     o_row;
  logic [9:0]     o_col;
  logic           o_last;
  logic           out_valid;
  logic           last_d;

  assign acc_ext  = {13'b0, acc};
  assign disp_ext = {6'b0, cmd.disp};
  assign row_ext  = {10'b0, cur_row};
  assign col_ext  = {10'b0, cur_col};
  assign last_d   = cmd.disp == nd_c - DW'(1);

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_valid && m_tready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      o_cost <= acc_ext[12:0];
      o_disp <= disp_ext[5:0];
      o_row  <= row_ext[9:0];
      o_col  <= col_ext[9:0];
      o_last <= last_d;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, o_col, o_row, o_disp, o_cost};
  assign m_tlast  = o_last;

  assign stat.cfg_busy = settle != 2'd0;
  assign stat.emit     = emit;
  assign stat.last_d   = last_d;
  assign stat.out_fire = out_valid && m_tready;

endmodule

>>> src/sadsc_ctrl.sv
// ----------------------------------------------------------------------------
// sadsc_ctrl
// Controller: sequences item accept, disparities and window taps.
// ----------------------------------------------------------------------------
module sadsc_ctrl #(
  parameter int WINDOW = 5
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  output sadsc_pkg::cmd_t     cmd,
  input  sadsc_pkg::status_t  stat
);

  typedef enum logic [2:0] {
    S_IDLE, S_INIT, S_TAP, S_WAIT, S_LOAD, S_OUT
  } state_t;

  state_t state;
  logic [sadsc_pkg::WIN_IW-1:0] i;
  logic [sadsc_pkg::WIN_IW-1:0] j;
  logic [sadsc_pkg::DISP_W-1:0] d;
  logic                         row_end;

  assign s_tready = (state == S_IDLE) && !stat.cfg_busy;
  assign row_end  = j == sadsc_pkg::WIN_IW'(WINDOW - 1);

  // commands
  always_comb begin
    cmd          = '0;
    cmd.accept   = s_tvalid && s_tready;
    cmd.acc_clr  = state == S_INIT;
    cmd.row_init = state == S_INIT;
    cmd.tap      = state == S_TAP;
    cmd.row_next = (state == S_TAP) && row_end;
    cmd.out_load = state == S_LOAD;
    cmd.col_tap  = j;
    cmd.disp     = d;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      i     <= '0;
      j     <= '0;
      d     <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (cmd.accept && stat.emit) begin
            d     <= '0;
            state <= S_INIT;
          end
        end
        S_INIT: begin
          i     <= '0;
          j     <= '0;
          state <= S_TAP;
        end
        S_TAP: begin
          if (row_end) begin
            j <= '0;
            if (i == sadsc_pkg::WIN_IW'(WINDOW - 1)) state <= S_WAIT;
            else i <= i + 1'b1;
          end else begin
            j <= j + 1'b1;
          end
        end
        S_WAIT: state <= S_LOAD;
        S_LOAD: state <= S_OUT;
        S_OUT: begin
          if (stat.out_fire) begin
            if (stat.last_d) begin
              state <= S_IDLE;
            end else begin
              d     <= d + 1'b1;
              state <= S_INIT;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> src/sadsc_checker.sv
// ----------------------------------------------------------------------------
// sadsc_checker
// Port-level checks of the cost volume block, bound to the top level.
// ----------------------------------------------------------------------------
module sadsc_checker (
  input logic        clk,
  input logic        rst,
  input logic        cfg_we,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [39:0] m_tdata,
  input logic        m_tlast
);

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output beat changed while stalled");

  // input is never taken while a cost waits
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid)
    else $error("input ready with output pending");

  // config write holds off input
  a_cfg_settle: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !s_tready)
    else $error("input ready right after config write");

  // more disparities follow a non-last beat
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> !s_tready)
    else $error("input ready in the middle of a cost run");

endmodule

bind sad_stereo_cost_volume sadsc_checker u_sadsc_checker (
  .clk      (clk),
  .rst      (rst),
  .cfg_we   (cfg_we),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);

>>> bench/sad_stereo_cost_volume_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sad_stereo_cost_volume_tb
// Self-checking bench for the streamed SAD stereo cost volume block.
// ----------------------------------------------------------------------------
// A short table of hand-made frames is run first, with the costs that are
// easy to see typed in. Small random frames follow, with random frame
// sizes, disparity counts and directions and pixel data. A behavioral
// model of the block predicts every cost beat. Both stream sides stall at
// random. One frame holds the output off for a long stretch, and the
// input pauses at every frame end until the output has drained.
// ----------------------------------------------------------------------------
module sad_stereo_cost_volume_tb;

  localparam int NUM_COLS    = 1024;
  localparam int NUM_ROWS    = 1024;
  localparam int NUM_DISP    = 64;
  localparam int HALF_W      = 2;
  localparam int STORE_SIZE  = 8 * NUM_COLS;
  localparam int ITEM_TARGET = 380;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int LONG_HOLD   = 2000;

  // beat kinds on the input tuser
  localparam logic FN_PIXEL = 1'b0;
  localparam logic FN_DRAIN = 1'b1;

  typedef struct {
    logic [12:0] cost;
    logic [5:0]  disparity;
    logic [9:0]  pixel_row;
    logic [9:0]  pixel_col;
    logic        last;
  } cost_beat_t;

  typedef struct {
    logic       fn;
    logic [7:0] left_px;
    logic [7:0] right_px;
    int         cost;   // -1 where the model value is used
  } table_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_addr;
  logic [10:0] cfg_data;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [39:0] m_tdata;
  logic        m_tlast;

  // model state
  logic [15:0] pair_store [STORE_SIZE];
  int          beat_pos;
  logic [10:0] rows_reg;
  logic [10:0] cols_reg;
  logic [6:0]  disp_reg;
  logic [1:0]  dir_reg;

  cost_beat_t  cost_expect_q[$];
  int          err_count;
  int          cycle_count;
  int          beat_count;
  bit          hold_long;
  bit          out_burst;
  bit          in_burst;

  table_row_t  frame_table [21] = '{
    // 1x1 frame, full-scale difference
    '{FN_PIXEL, 8'd255, 8'd0,   -1}, '{FN_DRAIN, 8'd0, 8'd0, -1},
    '{FN_DRAIN, 8'd0,   8'd0,   -1}, '{FN_DRAIN, 8'd0, 8'd0, -1},
    '{FN_DRAIN, 8'd0,   8'd0,  255},
    // drain before the pixel is ignored
    '{FN_DRAIN, 8'd9,   8'd9,   -1}, '{FN_PIXEL, 8'd0, 8'd255, -1},
    '{FN_DRAIN, 8'd0,   8'd0,   -1}, '{FN_DRAIN, 8'd0, 8'd0, -1},
    '{FN_DRAIN, 8'd0,   8'd0,   -1}, '{FN_DRAIN, 8'd0, 8'd0, 255},
    // surplus pixel after the frame acts as a drain
    '{FN_PIXEL, 8'd0,   8'd0,   -1}, '{FN_PIXEL, 8'd77, 8'd99, -1},
    '{FN_DRAIN, 8'd0,   8'd0,   -1}, '{FN_DRAIN, 8'd0, 8'd0, -1},
    '{FN_DRAIN, 8'd0,   8'd0,    0},
    // plain frame
    '{FN_PIXEL, 8'd200, 8'd13,  -1}, '{FN_DRAIN, 8'd0, 8'd0, -1},
    '{FN_DRAIN, 8'd0,   8'd0,   -1}, '{FN_DRAIN, 8'd0, 8'd0, -1},
    '{FN_DRAIN, 8'd0,   8'd0,  187}
  };

  sad_stereo_cost_volume i_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),   // left_pixel, right_pixel
    .s_tuser  (s_tuser),   // func
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),   // cost, disparity, pixel_row, pixel_col
    .m_tlast  (m_tlast)    // last
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int clamp_reg(int v, int hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  // window sum of absolute differences, off-image taps skipped
  function automatic int window_sad(int r, int c, int rc, int rows, int cols);
    int sum;
    int y;
    int xl;
    int xr;
    int lv;
    int rv;
    sum = 0;
    for (int i = -HALF_W; i <= HALF_W; i++) begin
      y = r + i;
      if (y < 0 || y >= rows) continue;
      for (int j = -HALF_W; j <= HALF_W; j++) begin
        xl = c + j;
        xr = rc + j;
        if (xl < 0 || xl >= cols || xr < 0 || xr >= cols) continue;
        lv = int'(pair_store[(y * cols + xl) % STORE_SIZE][7:0]);
        rv = int'(pair_store[(y * cols + xr) % STORE_SIZE][15:8]);
        sum += (lv > rv) ? lv - rv : rv - lv;
      end
    end
    return sum;
  endfunction

  // advance the model by one accepted input beat, queue the costs it emits
  function automatic int predict_costs(logic fn, logic [7:0] lp, logic [7:0] rp);
    int rows;
    int cols;
    int nd;
    int dir;
    int total;
    int lag;
    int ctr;
    int n;
    cost_beat_t cb;
    rows  = clamp_reg(int'(rows_reg), NUM_ROWS);
    cols  = clamp_reg(int'(cols_reg), NUM_COLS);
    nd    = clamp_reg(int'(disp_reg), NUM_DISP);
    dir   = (dir_reg == 2'd1) ? 1 : (dir_reg == 2'd0) ? 0 : -1;
    total = rows * cols;
    lag   = HALF_W * cols + HALF_W + nd - 1;
    n     = 0;
    if (fn == FN_DRAIN && beat_pos < total) return 0;
    if (fn == FN_PIXEL && beat_pos < total)
      pair_store[beat_pos % STORE_SIZE] = {rp, lp};
    if (beat_pos >= lag) begin
      ctr = beat_pos - lag;
      if (ctr < total) begin
        for (int d = 0; d < nd; d++) begin
          cb.cost      = 13'(window_sad(ctr / cols, ctr % cols, ctr % cols + dir * d,
                                        rows, cols));
          cb.disparity = 6'(d);
          cb.pixel_row = 10'(ctr / cols);
          cb.pixel_col = 10'(ctr % cols);
          cb.last      = (d == nd - 1);
          cost_expect_q.push_back(cb);
          n++;
        end
      end
    end
    if (beat_pos >= total - 1 + lag) beat_pos = 0;
    else beat_pos = beat_pos + 1;
    return n;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [10:0] val);
    @(negedge clk);
    cfg_we   = 1'b1;
    cfg_addr = idx;
    cfg_data = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      sadsc_pkg::CFG_ROWS: rows_reg = val;
      sadsc_pkg::CFG_COLS: cols_reg = val;
      sadsc_pkg::CFG_DISP: disp_reg = val[6:0];
      default:             dir_reg  = val[1:0];
    endcase
  endtask

  task automatic set_frame(int rows, int cols, int nd, int dir);
    write_reg(sadsc_pkg::CFG_ROWS, 11'(rows));
    write_reg(sadsc_pkg::CFG_COLS, 11'(cols));
    write_reg(sadsc_pkg::CFG_DISP, 11'(nd));
    write_reg(sadsc_pkg::CFG_DIR, 11'(dir));
  endtask

  // offer one beat, return the number of costs it is predicted to emit
  task automatic send_beat(logic fn, logic [7:0] lp, logic [7:0] rp, output int n);
    int gap;
    gap = in_burst ? 0 : $urandom_range(0, 4);
    @(negedge clk);
    if (gap > 0) begin
      s_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser  = fn;
    s_tdata  = {rp, lp};
    do @(posedge clk); while (!s_tready);
    n = predict_costs(fn, lp, rp);
    beat_count++;
  endtask

  // stop offering and wait for the output to drain
  task automatic drain_out();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (cost_expect_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  // one frame of random pixels, trailing beats until the counter wraps
  task automatic run_frame(int rows, int cols, int nd, int dir);
    int n;
    set_frame(rows, cols, nd, dir);
    in_burst = ($urandom_range(0, 3) == 0);
    for (int p = 0; p < clamp_reg(rows, NUM_ROWS) * clamp_reg(cols, NUM_COLS); p++) begin
      if ($urandom_range(0, 9) == 0)
        send_beat(FN_DRAIN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), n);
      send_beat(FN_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), n);
    end
    do begin
      if ($urandom_range(0, 5) == 0)
        send_beat(FN_PIXEL, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), n);
      else
        send_beat(FN_DRAIN, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)), n);
    end while (beat_pos != 0);
    drain_out();
  endtask

  // output side: random ready gaps, one long hold when asked
  initial begin
    int gap;
    m_tready = 1'b0;
    out_burst = 1'b0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (hold_long) begin
        m_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_long = 1'b0;
      end
      if ($urandom_range(0, 63) == 0) out_burst = ~out_burst;
      gap = out_burst ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        m_tready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      m_tready = 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  // compare each cost beat with the oldest prediction
  always @(posedge clk) begin
    cost_beat_t exp_b;
    if (!rst && m_tvalid && m_tready) begin
      if (cost_expect_q.size() == 0) begin
        $display("%0t: unexpected beat tdata=%h tlast=%b", $time, m_tdata, m_tlast);
        err_count++;
      end else begin
        exp_b = cost_expect_q.pop_front();
        if (m_tdata[12:0] !== exp_b.cost || m_tdata[18:13] !== exp_b.disparity ||
            m_tdata[28:19] !== exp_b.pixel_row || m_tdata[38:29] !== exp_b.pixel_col ||
            m_tdata[39] !== 1'b0 || m_tlast !== exp_b.last) begin
          $display("%0t: mismatch expected cost=%0d d=%0d row=%0d col=%0d last=%b",
                   $time, exp_b.cost, exp_b.disparity, exp_b.pixel_row,
                   exp_b.pixel_col, exp_b.last);
          $display("%0t:          actual   cost=%0d d=%0d row=%0d col=%0d last=%b",
                   $time, m_tdata[12:0], m_tdata[18:13], m_tdata[28:19],
                   m_tdata[38:29], m_tlast);
          err_count++;
        end
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // stimulus
  initial begin
    int n;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_addr = sadsc_pkg::CFG_ROWS;
    cfg_data = '0;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = FN_PIXEL;
    hold_long = 1'b0;
    in_burst = 1'b0;
    err_count = 0;
    cycle_count = 0;
    beat_count = 0;
    beat_pos = 0;
    rows_reg = sadsc_pkg::ROWS_RST;
    cols_reg = sadsc_pkg::COLS_RST;
    disp_reg = sadsc_pkg::DISP_RST;
    dir_reg  = sadsc_pkg::DIR_RST;
    foreach (pair_store[i]) pair_store[i] = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table on a 1x1 frame
    set_frame(1, 1, 1, 3);
    foreach (frame_table[i]) begin
      send_beat(frame_table[i].fn, frame_table[i].left_px, frame_table[i].right_px, n);
      if (frame_table[i].cost >= 0 && n > 0)
        cost_expect_q[$].cost = 13'(frame_table[i].cost);
    end
    drain_out();

    // register extremes, out-of-range values clamp
    run_frame(0, 0, 0, 2);
    run_frame(2, 3, 127, 0);

    // long output hold while the input keeps offering
    hold_long = 1'b1;
    run_frame(3, 4, 64, 1);

    // random frames
    while (beat_count < ITEM_TARGET)
      run_frame($urandom_range(1, 5), $urandom_range(1, 9),
                ($urandom_range(0, 7) == 0) ? 64 : $urandom_range(1, 8),
                $urandom_range(0, 3));

    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sad_stereo_cost_volume.f
src/sadsc_pkg.sv
src/sadsc_dp.sv
src/sadsc_ctrl.sv
src/sad_stereo_cost_volume.sv
src/sadsc_checker.sv
bench/sad_stereo_cost_volume_tb.sv
